[rtl/trrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trrc_pkg
// Shared types, constants and modular helpers of the two-rotor cipher.
// ----------------------------------------------------------------------------
package trrc_pkg;

  localparam int unsigned ALPHABET = 42;
  localparam int unsigned SYM_W    = 6;

  localparam logic [7:0] SYM_BASE = 8'd49;
  localparam logic [7:0] SYM_LAST = 8'd90;

  localparam logic [SYM_W-1:0] NOTCH_A = 6'd27;
  localparam logic [SYM_W-1:0] NOTCH_B = 6'd33;
  localparam logic [SYM_W-1:0] NOTCH_C = 6'd35;

  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [2:0] {
    OP_ENCRYPT   = 3'd0,
    OP_WR_LEFT   = 3'd1,
    OP_WR_RIGHT  = 3'd2,
    OP_WR_REFL   = 3'd3,
    OP_SET_POS   = 3'd4
  } op_e;

  typedef struct packed {
    logic vld;
    op_e  op;
    logic wr_ok;
    logic res;
    logic bad;
    sym_t idx;
    sym_t val;
    sym_t lpos;
    sym_t rpos;
  } stage_t;

  function automatic sym_t mod_add(sym_t a, sym_t b);
    logic [SYM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SYM_W+1)'(ALPHABET)) begin
      s = s - (SYM_W+1)'(ALPHABET);
    end
    return s[SYM_W-1:0];
  endfunction

  function automatic sym_t mod_sub(sym_t a, sym_t b);
    logic [SYM_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (SYM_W+1)'(ALPHABET) - {1'b0, b};
    end
    return s[SYM_W-1:0];
  endfunction

  function automatic sym_t mod_reduce(sym_t a);
    sym_t r;
    r = a;
    if (a >= SYM_W'(ALPHABET)) begin
      r = a - SYM_W'(ALPHABET);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/trrc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trrc_in_if / trrc_out_if
// Valid/ready channels for cipher requests and cipher results.
// ----------------------------------------------------------------------------
interface trrc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [5:0] entry_index;
  logic [5:0] entry_value;
  logic [7:0] in_char;
  logic [5:0] left_start;
  logic [5:0] right_start;

  modport source (output valid, opcode, entry_index, entry_value, in_char,
                  left_start, right_start, input ready);
  modport sink   (input valid, opcode, entry_index, entry_value, in_char,
                  left_start, right_start, output ready);
endinterface

interface trrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       bad_char;

  modport source (output valid, out_char, bad_char, input ready);
  modport sink   (input valid, out_char, bad_char, output ready);
endinterface
`default_nettype wire

[rtl/trrc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trrc_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module trrc_ram #(
  parameter int unsigned Depth = 42,
  parameter int unsigned Width = 6,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/trrc_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trrc_step
// Request decode and rotor stepping. Holds both rotor positions and forms
// the first pipeline stage together with the right rotor lookup address.
// ----------------------------------------------------------------------------
module trrc_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic            accept_i,
  input  wire logic [2:0]      opcode_i,
  input  wire logic [5:0]      entry_index_i,
  input  wire logic [5:0]      entry_value_i,
  input  wire logic [7:0]      in_char_i,
  input  wire logic [5:0]      left_start_i,
  input  wire logic [5:0]      right_start_i,
  output trrc_pkg::stage_t     stage_o,
  output trrc_pkg::sym_t       raddr_o
);

  trrc_pkg::sym_t lpos_q, lpos_d;
  trrc_pkg::sym_t rpos_q, rpos_d;
  trrc_pkg::sym_t rpos_step, lpos_step, code;
  trrc_pkg::op_e  op;
  logic [7:0]     code_full;
  logic           bad, notch;

  assign op        = trrc_pkg::op_e'(opcode_i);
  assign bad       = (in_char_i < trrc_pkg::SYM_BASE) || (in_char_i > trrc_pkg::SYM_LAST);
  assign code_full = in_char_i - trrc_pkg::SYM_BASE;
  assign code      = code_full[trrc_pkg::SYM_W-1:0];
  assign rpos_step = trrc_pkg::mod_add(rpos_q, trrc_pkg::SYM_W'(1));
  assign notch     = (rpos_step == trrc_pkg::NOTCH_A) || (rpos_step == trrc_pkg::NOTCH_B) ||
                     (rpos_step == trrc_pkg::NOTCH_C);
  assign lpos_step = notch ? trrc_pkg::mod_add(lpos_q, trrc_pkg::SYM_W'(1)) : lpos_q;

  always_comb begin
    lpos_d = lpos_q;
    rpos_d = rpos_q;
    unique case (op)
      trrc_pkg::OP_ENCRYPT: begin
        if (!bad) begin
          lpos_d = lpos_step;
          rpos_d = rpos_step;
        end
      end
      trrc_pkg::OP_SET_POS: begin
        lpos_d = trrc_pkg::mod_reduce(left_start_i);
        rpos_d = trrc_pkg::mod_reduce(right_start_i);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpos_q <= '0;
      rpos_q <= '0;
    end else if (accept_i) begin
      lpos_q <= lpos_d;
      rpos_q <= rpos_d;
    end
  end

  always_comb begin
    stage_o.vld   = valid_i;
    stage_o.op    = op;
    stage_o.wr_ok = (entry_index_i < trrc_pkg::SYM_W'(trrc_pkg::ALPHABET)) &&
                    (entry_value_i < trrc_pkg::SYM_W'(trrc_pkg::ALPHABET));
    stage_o.res   = (op == trrc_pkg::OP_ENCRYPT);
    stage_o.bad   = bad;
    stage_o.idx   = entry_index_i;
    stage_o.val   = entry_value_i;
    stage_o.lpos  = lpos_step;
    stage_o.rpos  = rpos_step;
  end

  assign raddr_o = trrc_pkg::mod_add(code, rpos_step);

endmodule
`default_nettype wire

[rtl/two_rotor_reflector_cipher.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_rotor_reflector_cipher
// Two-rotor cipher with reflector over the symbols '1' to 'Z', built as a
// pipeline of five table memories.
//
//   Channel  Dir  Transaction
//   in_i     in   opcode, entry_index, entry_value, in_char, starts
//   out_o    out  out_char, bad_char (encrypt requests only)
//
// One request is accepted per cycle unless the pipeline holds; each of the
// five table memories is read once per request in its own stage, and a
// table write lands in the stage where that table is read, so requests see
// tables in order. A result passes through the stage registers s_q[1] to
// s_q[NumStages] into the output register. Reset clears both rotor positions;
// table contents stay undefined until written. The pipeline holds only when
// its last stage has a result and the output is occupied and not ready.
// ----------------------------------------------------------------------------
module two_rotor_reflector_cipher (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  trrc_in_if.sink     in_i,
  trrc_out_if.source  out_o
);

  localparam int unsigned NumStages = 5;

  trrc_pkg::stage_t s0;
  trrc_pkg::stage_t s_q [1:NumStages];
  trrc_pkg::sym_t   rt_addr, lt_addr, rf_addr, li_addr, ri_addr;
  trrc_pkg::sym_t   rt_d, lt_d, rf_d, li_d, ri_d;
  trrc_pkg::sym_t   res_code;
  logic             adv;
  logic             last_res;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_char_q;
  logic             bad_q;

  assign last_res = s_q[NumStages].vld && s_q[NumStages].res;
  assign adv      = !last_res || !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  trrc_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .accept_i      (in_i.valid && adv),
    .opcode_i      (in_i.opcode),
    .entry_index_i (in_i.entry_index),
    .entry_value_i (in_i.entry_value),
    .in_char_i     (in_i.in_char),
    .left_start_i  (in_i.left_start),
    .right_start_i (in_i.right_start),
    .stage_o       (s0),
    .raddr_o       (rt_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NumStages; k++) begin
        s_q[k] <= '0;
      end
    end else if (adv) begin
      s_q[1] <= s0;
      for (int k = 2; k <= NumStages; k++) begin
        s_q[k] <= s_q[k-1];
      end
    end
  end

  trrc_ram #(.Depth(trrc_pkg::ALPHABET), .Width(trrc_pkg::SYM_W)) u_right (
    .clk_i   (clk_i),
    .we_i    (adv && s0.vld && s0.wr_ok && (s0.op == trrc_pkg::OP_WR_RIGHT)),
    .waddr_i (s0.idx),
    .wdata_i (s0.val),
    .re_i    (adv),
    .raddr_i (rt_addr),
    .rdata_o (rt_d)
  );

  assign lt_addr = trrc_pkg::mod_add(trrc_pkg::mod_sub(rt_d, s_q[1].rpos), s_q[1].lpos);

  trrc_ram #(.Depth(trrc_pkg::ALPHABET), .Width(trrc_pkg::SYM_W)) u_left (
    .clk_i   (clk_i),
    .we_i    (adv && s_q[1].vld && s_q[1].wr_ok && (s_q[1].op == trrc_pkg::OP_WR_LEFT)),
    .waddr_i (s_q[1].idx),
    .wdata_i (s_q[1].val),
    .re_i    (adv),
    .raddr_i (lt_addr),
    .rdata_o (lt_d)
  );

  assign rf_addr = trrc_pkg::mod_sub(lt_d, s_q[2].lpos);

  trrc_ram #(.Depth(trrc_pkg::ALPHABET), .Width(trrc_pkg::SYM_W)) u_refl (
    .clk_i   (clk_i),
    .we_i    (adv && s_q[2].vld && s_q[2].wr_ok && (s_q[2].op == trrc_pkg::OP_WR_REFL)),
    .waddr_i (s_q[2].idx),
    .wdata_i (s_q[2].val),
    .re_i    (adv),
    .raddr_i (rf_addr),
    .rdata_o (rf_d)
  );

  assign li_addr = trrc_pkg::mod_add(rf_d, s_q[3].lpos);

  trrc_ram #(.Depth(trrc_pkg::ALPHABET), .Width(trrc_pkg::SYM_W)) u_left_inv (
    .clk_i   (clk_i),
    .we_i    (adv && s_q[3].vld && s_q[3].wr_ok && (s_q[3].op == trrc_pkg::OP_WR_LEFT)),
    .waddr_i (s_q[3].val),
    .wdata_i (s_q[3].idx),
    .re_i    (adv),
    .raddr_i (li_addr),
    .rdata_o (li_d)
  );

  assign ri_addr = trrc_pkg::mod_add(trrc_pkg::mod_sub(li_d, s_q[4].lpos), s_q[4].rpos);

  trrc_ram #(.Depth(trrc_pkg::ALPHABET), .Width(trrc_pkg::SYM_W)) u_right_inv (
    .clk_i   (clk_i),
    .we_i    (adv && s_q[4].vld && s_q[4].wr_ok && (s_q[4].op == trrc_pkg::OP_WR_RIGHT)),
    .waddr_i (s_q[4].val),
    .wdata_i (s_q[4].idx),
    .re_i    (adv),
    .raddr_i (ri_addr),
    .rdata_o (ri_d)
  );

  assign res_code = trrc_pkg::mod_sub(ri_d, s_q[NumStages].rpos);

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && last_res) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_res) begin
      bad_q      <= s_q[NumStages].bad;
      out_char_q <= s_q[NumStages].bad ? 8'd0 : ({2'b00, res_code} + trrc_pkg::SYM_BASE);
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.out_char = out_char_q;
  assign out_o.bad_char = bad_q;

  a_ready_when_last_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !last_res |-> in_i.ready)
    else $error("Input stalled although the last stage holds no result.");

  a_bad_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_char |-> out_o.out_char == 8'd0)
    else $error("A bad character result carries a nonzero character.");

  a_pos_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q[1].vld && s_q[1].res && !s_q[1].bad |->
      (s_q[1].rpos < trrc_pkg::SYM_W'(trrc_pkg::ALPHABET)) &&
      (s_q[1].lpos < trrc_pkg::SYM_W'(trrc_pkg::ALPHABET)))
    else $error("Rotor position outside the alphabet.");

  a_stall_holds_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready && last_res |=> out_o.valid && $stable(out_o.out_char))
    else $error("Pending result changed while the pipeline was stalled.");

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-rotor reflector cipher. Random rotor and
// reflector permutations are loaded first, then a directed run covers the
// alphabet edges, bad characters, notch steps, position reduction, ignored
// opcodes and ignored writes. A long random run follows, made of position
// sets with character bursts, table rewiring and reloads, and noise. A
// scoreboard predicts every result and checks each output transaction.
// Both channels idle at random, and the output side holds off for long
// stretches so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import trrc_pkg::*;

  localparam logic [2:0]  OP_SPARE_5       = 3'd5;
  localparam logic [2:0]  OP_SPARE_6       = 3'd6;
  localparam logic [2:0]  OP_SPARE_7       = 3'd7;
  localparam int unsigned RANDOM_ITEMS     = 1050;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 30;
  localparam int unsigned LIMIT_DELAY      = 40_000_000;

  typedef struct packed {
    logic [2:0] opcode;
    sym_t       entry_index;
    sym_t       entry_value;
    logic [7:0] in_char;
    sym_t       left_start;
    sym_t       right_start;
  } cipher_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       bad_char;
  } cipher_res_t;

  class cipher_scoreboard;
    sym_t          rot_left  [ALPHABET];
    sym_t          rot_right [ALPHABET];
    sym_t          refl      [ALPHABET];
    sym_t          inv_left  [ALPHABET];
    sym_t          inv_right [ALPHABET];
    sym_t          pos_left;
    sym_t          pos_right;
    cipher_res_t   pending[$];
    int unsigned   mismatches;

    function new();
      pos_left   = '0;
      pos_right  = '0;
      mismatches = 0;
    endfunction

    function int unsigned shift(int unsigned c, sym_t p);
      return (c + p) % ALPHABET;
    endfunction

    function int unsigned unshift(sym_t v, sym_t p);
      return ((v % ALPHABET) + ALPHABET - p) % ALPHABET;
    endfunction

    function sym_t advance(sym_t p);
      return sym_t'((p + 1) % ALPHABET);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    function void note_request(cipher_req_t r);
      int unsigned c;
      cipher_res_t res;
      if (r.opcode == OP_WR_LEFT || r.opcode == OP_WR_RIGHT || r.opcode == OP_WR_REFL) begin
        if (r.entry_index < ALPHABET && r.entry_value < ALPHABET) begin
          if (r.opcode == OP_WR_LEFT) begin
            rot_left[r.entry_index] = r.entry_value;
            inv_left[r.entry_value] = r.entry_index;
          end else if (r.opcode == OP_WR_RIGHT) begin
            rot_right[r.entry_index] = r.entry_value;
            inv_right[r.entry_value] = r.entry_index;
          end else begin
            refl[r.entry_index] = r.entry_value;
          end
        end
      end else if (r.opcode == OP_SET_POS) begin
        pos_left  = sym_t'(r.left_start % ALPHABET);
        pos_right = sym_t'(r.right_start % ALPHABET);
      end else if (r.opcode == OP_ENCRYPT) begin
        if (r.in_char < SYM_BASE || r.in_char > SYM_LAST) begin
          res.out_char = 8'd0;
          res.bad_char = 1'b1;
        end else begin
          pos_right = advance(pos_right);
          if (pos_right == NOTCH_A || pos_right == NOTCH_B || pos_right == NOTCH_C) begin
            pos_left = advance(pos_left);
          end
          c = r.in_char - SYM_BASE;
          c = unshift(rot_right[shift(c, pos_right)], pos_right);
          c = unshift(rot_left[shift(c, pos_left)], pos_left);
          c = refl[c] % ALPHABET;
          c = unshift(inv_left[shift(c, pos_left)], pos_left);
          c = unshift(inv_right[shift(c, pos_right)], pos_right);
          res.out_char = 8'(c + SYM_BASE);
          res.bad_char = 1'b0;
        end
        pending.push_back(res);
      end
    endfunction

    task check_result(logic [7:0] out_char, logic bad_char);
      cipher_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", out_char, 0);
      end else begin
        want = pending.pop_front();
        if (out_char !== want.out_char) begin
          report_mismatch("out_char", out_char, want.out_char);
        end
        if (bad_char !== want.bad_char) begin
          report_mismatch("bad_char", bad_char, want.bad_char);
        end
      end
    endtask

    task check_leftover();
      if (pending.size() != 0) begin
        report_mismatch("results never delivered", pending.size(), 0);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  trrc_in_if  in_bus ();
  trrc_out_if out_bus ();

  two_rotor_reflector_cipher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  cipher_scoreboard sb = new();

  int unsigned deck     [ALPHABET];
  int unsigned gen_left [ALPHABET];
  int unsigned gen_right[ALPHABET];
  int unsigned gen_refl [ALPHABET];
  int unsigned effective_items;
  bit          no_idle;
  bit          long_hold_req;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic cipher_req_t random_req();
    cipher_req_t r;
    r.opcode      = 3'($urandom);
    r.entry_index = sym_t'($urandom);
    r.entry_value = sym_t'($urandom);
    r.in_char     = 8'($urandom);
    r.left_start  = sym_t'($urandom);
    r.right_start = sym_t'($urandom);
    return r;
  endfunction

  function automatic cipher_req_t write_req(logic [2:0] op, int unsigned idx, int unsigned val);
    cipher_req_t r;
    r             = random_req();
    r.opcode      = op;
    r.entry_index = sym_t'(idx);
    r.entry_value = sym_t'(val);
    return r;
  endfunction

  function automatic cipher_req_t pos_req(int unsigned lpos, int unsigned rpos);
    cipher_req_t r;
    r             = random_req();
    r.opcode      = OP_SET_POS;
    r.left_start  = sym_t'(lpos);
    r.right_start = sym_t'(rpos);
    return r;
  endfunction

  function automatic cipher_req_t char_req(int unsigned ch);
    cipher_req_t r;
    r         = random_req();
    r.opcode  = OP_ENCRYPT;
    r.in_char = 8'(ch);
    return r;
  endfunction

  function automatic int unsigned alpha_char();
    return $urandom_range(SYM_BASE, SYM_LAST);
  endfunction

  function automatic bit is_effective(cipher_req_t r);
    if (r.opcode == OP_ENCRYPT || r.opcode == OP_SET_POS) begin
      return 1'b1;
    end
    if (r.opcode == OP_WR_LEFT || r.opcode == OP_WR_RIGHT || r.opcode == OP_WR_REFL) begin
      return r.entry_index < ALPHABET && r.entry_value < ALPHABET;
    end
    return 1'b0;
  endfunction

  task automatic send_req(input cipher_req_t r);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= r.opcode;
    in_bus.entry_index <= r.entry_index;
    in_bus.entry_value <= r.entry_value;
    in_bus.in_char     <= r.in_char;
    in_bus.left_start  <= r.left_start;
    in_bus.right_start <= r.right_start;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_request(r);
    if (is_effective(r)) begin
      effective_items++;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic shuffle_deck();
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < ALPHABET; i++) begin
      deck[i] = i;
    end
    for (int i = ALPHABET - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = deck[i];
      deck[i] = deck[j];
      deck[j] = t;
    end
  endtask

  task automatic load_table(logic [2:0] op);
    int unsigned idx;
    int unsigned val;
    shuffle_deck();
    for (int k = 0; k < ALPHABET; k++) begin
      idx = deck[k];
      if (op == OP_WR_LEFT) begin
        val = gen_left[idx];
      end else if (op == OP_WR_RIGHT) begin
        val = gen_right[idx];
      end else begin
        val = gen_refl[idx];
      end
      send_req(write_req(op, idx, val));
    end
  endtask

  task automatic new_rotor(logic [2:0] op);
    shuffle_deck();
    if (op == OP_WR_LEFT) begin
      gen_left = deck;
    end else begin
      gen_right = deck;
    end
    load_table(op);
  endtask

  task automatic new_reflector();
    shuffle_deck();
    for (int k = 0; k < ALPHABET / 2; k++) begin
      gen_refl[deck[2*k]]   = deck[2*k+1];
      gen_refl[deck[2*k+1]] = deck[2*k];
    end
    load_table(OP_WR_REFL);
  endtask

  task automatic rewire();
    int unsigned i;
    int unsigned j;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned d;
    int unsigned t;
    int unsigned sel;
    sel = $urandom_range(0, 2);
    if (sel < 2) begin
      i = $urandom_range(0, ALPHABET - 1);
      j = (i + $urandom_range(1, ALPHABET - 1)) % ALPHABET;
      if (sel == 0) begin
        t = gen_left[i];
        gen_left[i] = gen_left[j];
        gen_left[j] = t;
        send_req(write_req(OP_WR_LEFT, i, gen_left[i]));
        send_req(write_req(OP_WR_LEFT, j, gen_left[j]));
      end else begin
        t = gen_right[i];
        gen_right[i] = gen_right[j];
        gen_right[j] = t;
        send_req(write_req(OP_WR_RIGHT, i, gen_right[i]));
        send_req(write_req(OP_WR_RIGHT, j, gen_right[j]));
      end
    end else begin
      a = $urandom_range(0, ALPHABET - 1);
      b = gen_refl[a];
      do begin
        c = $urandom_range(0, ALPHABET - 1);
      end while (c == a || c == b);
      d = gen_refl[c];
      gen_refl[a] = c;
      gen_refl[c] = a;
      gen_refl[b] = d;
      gen_refl[d] = b;
      send_req(write_req(OP_WR_REFL, a, c));
      send_req(write_req(OP_WR_REFL, c, a));
      send_req(write_req(OP_WR_REFL, b, d));
      send_req(write_req(OP_WR_REFL, d, b));
    end
  endtask

  task automatic char_burst(int unsigned len);
    repeat (len) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(char_req($urandom_range(0, 255)));
      end else begin
        send_req(char_req(alpha_char()));
      end
    end
  endtask

  task automatic random_positions();
    int unsigned sel;
    int unsigned notch_side [5] = '{26, 32, 34, 40, 41};
    sel = $urandom_range(0, 3);
    if (sel < 2) begin
      send_req(pos_req($urandom_range(0, ALPHABET - 1), $urandom_range(0, ALPHABET - 1)));
    end else if (sel == 2) begin
      send_req(pos_req($urandom_range(0, ALPHABET - 1), notch_side[$urandom_range(0, 4)]));
    end else begin
      send_req(pos_req($urandom_range(0, 63), $urandom_range(0, 63)));
    end
  endtask

  task automatic noise();
    int unsigned sel;
    repeat ($urandom_range(1, 4)) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
        send_req(write_req(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), $urandom, $urandom));
      end else if (sel == 1) begin
        send_req(write_req(3'($urandom_range(OP_WR_LEFT, OP_WR_REFL)),
                           $urandom_range(ALPHABET, 63), $urandom_range(0, 63)));
      end else if (sel == 2) begin
        send_req(write_req(3'($urandom_range(OP_WR_LEFT, OP_WR_REFL)),
                           $urandom_range(0, 63), $urandom_range(ALPHABET, 63)));
      end else begin
        send_req(char_req($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic pressure_burst();
    no_idle       = 1'b1;
    long_hold_req = 1'b1;
    repeat (48) send_req(char_req(alpha_char()));
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        run_len = $urandom_range(1, 12);
        @(negedge clk_i);
        out_bus.ready <= 1'b1;
        repeat (run_len - 1) @(negedge clk_i);
        stall_len = pick_gap();
        if (stall_len > 0) begin
          @(negedge clk_i);
          out_bus.ready <= 1'b0;
          repeat (stall_len - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Every output transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_result(out_bus.out_char, out_bus.bad_char);
    end
  end

  initial begin
    #(LIMIT_DELAY);
    $display("two_rotor_reflector_cipher verification failed");
    $finish;
  end

  initial begin
    int unsigned sel;
    bit          hold_one;
    bit          hold_two;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.opcode      = '0;
    in_bus.entry_index = '0;
    in_bus.entry_value = '0;
    in_bus.in_char     = '0;
    in_bus.left_start  = '0;
    in_bus.right_start = '0;
    no_idle            = 1'b0;
    long_hold_req      = 1'b0;
    hold_one           = 1'b0;
    hold_two           = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every table entry is written before the first character is sent.
    new_rotor(OP_WR_LEFT);
    new_rotor(OP_WR_RIGHT);
    new_reflector();

    send_req(pos_req(0, 0));
    send_req(char_req(SYM_BASE));
    send_req(char_req(SYM_LAST));
    send_req(char_req(SYM_BASE - 1));
    send_req(char_req(SYM_LAST + 1));
    send_req(char_req(0));
    send_req(char_req(255));
    send_req(char_req(8'h41));
    send_req(pos_req(5, 26));
    send_req(char_req(alpha_char()));
    send_req(pos_req(41, 32));
    send_req(char_req(alpha_char()));
    send_req(pos_req(7, 34));
    send_req(char_req(alpha_char()));
    send_req(pos_req(63, 63));
    send_req(char_req(alpha_char()));
    send_req(pos_req(0, 41));
    send_req(char_req(alpha_char()));
    send_req(write_req(OP_SPARE_5, $urandom, $urandom));
    send_req(write_req(OP_SPARE_6, $urandom, $urandom));
    send_req(write_req(OP_SPARE_7, $urandom, $urandom));
    send_req(write_req(OP_WR_LEFT, ALPHABET, 0));
    send_req(write_req(OP_WR_RIGHT, 5, 63));
    send_req(write_req(OP_WR_REFL, 63, 63));
    send_req(pos_req(42, 47));
    send_req(char_req(alpha_char()));

    effective_items = 0;
    while (effective_items < RANDOM_ITEMS) begin
      if (!hold_one && effective_items >= 150) begin
        hold_one = 1'b1;
        pressure_burst();
      end else if (!hold_two && effective_items >= 700) begin
        hold_two = 1'b1;
        pressure_burst();
      end
      no_idle = ($urandom_range(0, 9) == 0);
      sel     = $urandom_range(0, 99);
      if (sel < 50) begin
        if ($urandom_range(0, 9) < 7) begin
          random_positions();
        end
        char_burst($urandom_range(4, 30));
      end else if (sel < 65) begin
        char_burst($urandom_range(1, 20));
      end else if (sel < 80) begin
        rewire();
      end else if (sel < 83) begin
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
          new_rotor(OP_WR_LEFT);
        end else if (sel == 1) begin
          new_rotor(OP_WR_RIGHT);
        end else begin
          new_reflector();
        end
      end else begin
        noise();
      end
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_leftover();
    if (sb.mismatches == 0) begin
      $display("two_rotor_reflector_cipher verification clean");
    end else begin
      $display("two_rotor_reflector_cipher verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
